### src/c8ie_pkg.sv
// Shared types, codes, constants and a helper function of the CHIP-8 execute unit.
`default_nettype none

package c8ie_pkg;

  // Default sizes of the machine.
  localparam int MEMORY_BYTES_DEF = 4096;
  localparam int STACK_DEPTH_DEF  = 16;
  localparam int LOAD_ADDRESS_DEF = 512;

  localparam int FONT_BYTES = 80;

  // Command codes of an input item.
  typedef enum logic [1:0] {
    CMD_EXEC  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Sequencing class of a decoded opcode.
  typedef enum logic [2:0] {
    CLS_SIMPLE,
    CLS_FLAG,
    CLS_BCD,
    CLS_STORE,
    CLS_LOAD
  } op_class_e;

  // Work step that the controller orders the datapath to do.
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_CLEAR,
    DP_ACCEPT,
    DP_READ_X,
    DP_READ_Y,
    DP_READ_0,
    DP_EXEC,
    DP_WRITE_VF,
    DP_BCD,
    DP_ST_RD,
    DP_ST_WR,
    DP_LD_RD,
    DP_LD_WR,
    DP_MEM_WR,
    DP_MEM_RD,
    DP_MEM_CAP
  } dp_step_e;

  // Status that the datapath reports to the controller.
  typedef struct packed {
    cmd_e      cmd;
    op_class_e op_class;
    logic      clear_last;
    logic      cnt_last;
  } dp_status_t;

  // Opcode fields and special words.
  localparam logic [15:0] OP_CLS     = 16'h00E0;
  localparam logic [15:0] OP_RET     = 16'h00EE;
  localparam logic [7:0]  KK_SKP     = 8'h9E;
  localparam logic [7:0]  KK_SKNP    = 8'hA1;
  localparam logic [7:0]  KK_LD_DT   = 8'h07;
  localparam logic [7:0]  KK_LD_KEY  = 8'h0A;
  localparam logic [7:0]  KK_SET_DT  = 8'h15;
  localparam logic [7:0]  KK_SET_ST  = 8'h18;
  localparam logic [7:0]  KK_ADD_I   = 8'h1E;
  localparam logic [7:0]  KK_FONT    = 8'h29;
  localparam logic [7:0]  KK_BCD     = 8'h33;
  localparam logic [7:0]  KK_STORE   = 8'h55;
  localparam logic [7:0]  KK_LOAD    = 8'h65;

  // Hex digit font, five rows per digit.
  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hf0, 8'h90, 8'h90, 8'h90, 8'hf0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hf0, 8'h10, 8'hf0, 8'h80, 8'hf0, 8'hf0, 8'h10, 8'hf0, 8'h10, 8'hf0,
    8'h90, 8'h90, 8'hf0, 8'h10, 8'h10, 8'hf0, 8'h80, 8'hf0, 8'h10, 8'hf0,
    8'hf0, 8'h80, 8'hf0, 8'h90, 8'hf0, 8'hf0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hf0, 8'h90, 8'hf0, 8'h90, 8'hf0, 8'hf0, 8'h90, 8'hf0, 8'h10, 8'hf0,
    8'hf0, 8'h90, 8'hf0, 8'h90, 8'h90, 8'he0, 8'h90, 8'he0, 8'h90, 8'he0,
    8'hf0, 8'h80, 8'h80, 8'h80, 8'hf0, 8'he0, 8'h90, 8'h90, 8'h90, 8'he0,
    8'hf0, 8'h80, 8'hf0, 8'h80, 8'hf0, 8'hf0, 8'h80, 8'hf0, 8'h80, 8'h80
  };

  // Decimal digits of a byte: hundreds in [11:8], tens in [7:4], ones in [3:0].
  function automatic logic [11:0] bcd_digits(input logic [7:0] v);
    logic [3:0]  hund;
    logic [7:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [7:0]  ones;
    if (v >= 8'd200) begin
      hund = 4'd2;
      rem  = v - 8'd200;
    end else if (v >= 8'd100) begin
      hund = 4'd1;
      rem  = v - 8'd100;
    end else begin
      hund = 4'd0;
      rem  = v;
    end
    // Reciprocal multiply: exact for values below one hundred.
    prod = 15'(rem) * 15'd205;
    tens = prod[14:11];
    ones = rem - 8'(tens) * 8'd10;
    return {hund, tens, ones[3:0]};
  endfunction

endpackage

`default_nettype wire

### src/c8ie_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module c8ie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One access per cycle; the read returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

### src/c8ie_ctrl.sv
// Controller state machine that sequences the steps of each command.
`default_nettype none

module c8ie_ctrl
  import c8ie_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire dp_status_t status_i,
  output dp_step_e        step_o,
  output logic            busy_o,
  output logic            done_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_RX, S_RY, S_R0, S_EXEC, S_WF,
    S_BCD, S_ST_RD, S_ST_WR, S_LD_RD, S_LD_WR, S_MWR, S_MRD, S_MCAP
  } state_e;

  localparam state_e S_DONE = S_IDLE;

  state_e state_q, state_d;
  logic   done_q, busy_q;
  logic   idle;

  assign idle = (state_q == S_IDLE);

  // Next state and the datapath step of this cycle.
  always_comb begin
    state_d = state_q;
    step_o  = DP_IDLE;
    case (state_q)
      S_CLEAR: begin
        step_o = DP_CLEAR;
        if (status_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          step_o  = DP_ACCEPT;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status_i.cmd)
          CMD_EXEC:  state_d = S_RX;
          CMD_WRITE: state_d = S_MWR;
          CMD_READ:  state_d = S_MRD;
          default:   state_d = S_DONE;
        endcase
      end
      S_RX: begin
        step_o  = DP_READ_X;
        state_d = S_RY;
      end
      S_RY: begin
        step_o  = DP_READ_Y;
        state_d = S_R0;
      end
      S_R0: begin
        step_o  = DP_READ_0;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        step_o = DP_EXEC;
        case (status_i.op_class)
          CLS_FLAG:  state_d = S_WF;
          CLS_BCD:   state_d = S_BCD;
          CLS_STORE: state_d = S_ST_RD;
          CLS_LOAD:  state_d = S_LD_RD;
          default:   state_d = S_DONE;
        endcase
      end
      S_WF: begin
        step_o  = DP_WRITE_VF;
        state_d = S_DONE;
      end
      S_BCD: begin
        step_o = DP_BCD;
        if (status_i.cnt_last) state_d = S_DONE;
      end
      S_ST_RD: begin
        step_o  = DP_ST_RD;
        state_d = S_ST_WR;
      end
      S_ST_WR: begin
        step_o  = DP_ST_WR;
        state_d = status_i.cnt_last ? S_DONE : S_ST_RD;
      end
      S_LD_RD: begin
        step_o  = DP_LD_RD;
        state_d = S_LD_WR;
      end
      S_LD_WR: begin
        step_o  = DP_LD_WR;
        state_d = status_i.cnt_last ? S_DONE : S_LD_RD;
      end
      S_MWR: begin
        step_o  = DP_MEM_WR;
        state_d = S_DONE;
      end
      S_MRD: begin
        step_o  = DP_MEM_RD;
        state_d = S_MCAP;
      end
      S_MCAP: begin
        step_o  = DP_MEM_CAP;
        state_d = S_DONE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State with the registered strobe and busy flag. The result shows in the
  // cycle after the last work step, while the idle state already takes a
  // new transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
      busy_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      done_q  <= (state_d == S_DONE) && !(idle && !start_i)
                 && (state_q != S_CLEAR);
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

### src/c8ie_dpath.sv
// Datapath: machine registers, memories, decode and execute logic.
`default_nettype none

module c8ie_dpath
  import c8ie_pkg::*;
#(
  parameter int MEMORY_BYTES = MEMORY_BYTES_DEF,
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
  parameter int LOAD_ADDRESS = LOAD_ADDRESS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_step_e    step_i,
  output dp_status_t       status_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [15:0] opcode_i,
  input  wire logic [11:0] mem_address_i,
  input  wire logic [7:0]  write_byte_i,
  input  wire logic [15:0] keypad_mask_i,
  input  wire logic [3:0]  waited_key_i,
  input  wire logic [7:0]  random_byte_i,
  output logic [11:0]      next_pc_o,
  output logic [11:0]      index_value_o,
  output logic [7:0]       flag_value_o,
  output logic [7:0]       delay_value_o,
  output logic [7:0]       sound_value_o,
  output logic [7:0]       read_byte_o,
  output logic             display_request_o,
  output logic             stack_fault_o
);

  localparam int MAW = $clog2(MEMORY_BYTES);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Latched item.
  cmd_e        cmd_q;
  logic [15:0] op_q;
  logic [11:0] maddr_q;
  logic [7:0]  wbyte_q;
  logic [15:0] keys_q;
  logic [3:0]  wkey_q;
  logic [7:0]  rnd_q;

  // Machine state.
  logic [11:0] pc_q, i_q;
  logic [7:0]  vf_q, dt_q, snd_q;
  logic [4:0]  lvl_q;
  logic [15:0] gp_vld_q;

  // Work registers.
  logic [7:0]     vx_q, vy_q, vfnew_q, rd_q;
  logic [11:0]    sret_q;
  logic [3:0]     cnt_q;
  logic           gp_rvld_q, mrng_q, disp_q, fault_q;
  logic [MAW-1:0] clr_q;

  // Opcode fields.
  logic [3:0]  nib, x, y, n4;
  logic [7:0]  kk;
  logic [11:0] nnn;
  assign nib = op_q[15:12];
  assign x   = op_q[11:8];
  assign y   = op_q[7:4];
  assign n4  = op_q[3:0];
  assign kk  = op_q[7:0];
  assign nnn = op_q[11:0];

  // Register file access; entries not yet written read as zero.
  logic       gp_we;
  logic [3:0] gp_addr;
  logic [7:0] gp_wdata, gp_rdata, gp_val;

  assign gp_val = gp_rvld_q ? gp_rdata : 8'd0;

  c8ie_ram #(.WIDTH(8), .DEPTH(16)) u_gp_ram (
    .clk_i  (clk_i),
    .we_i   (gp_we),
    .addr_i (gp_addr),
    .wdata_i(gp_wdata),
    .rdata_o(gp_rdata)
  );

  // Return stack.
  logic           stk_we;
  logic [SAW-1:0] stk_addr;
  logic [11:0]    stk_rdata;
  logic [4:0]     lvl_m1;

  assign lvl_m1 = lvl_q - 5'd1;

  c8ie_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .addr_i (stk_addr),
    .wdata_i(pc_q),
    .rdata_o(stk_rdata)
  );

  // Byte memory.
  logic           mem_we, mem_in_range;
  logic [11:0]    mem_a12;
  logic [MAW-1:0] mem_addr;
  logic [7:0]     mem_wdata, mem_rdata, mem_val, font_byte;
  logic [3:0]     cnt_p1;
  logic [11:0]    bcd;
  logic [7:0]     bcd_digit;

  assign cnt_p1 = cnt_q + 4'd1;
  assign mem_val = mrng_q ? mem_rdata : 8'd0;
  assign bcd = bcd_digits(vx_q);
  assign font_byte = (32'(clr_q) < FONT_BYTES) ? FONT[7'(clr_q)] : 8'd0;

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    bcd_digit = {4'd0, bcd[11:8]};
      2'd1:    bcd_digit = {4'd0, bcd[7:4]};
      default: bcd_digit = {4'd0, bcd[3:0]};
    endcase
  end

  c8ie_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_byte_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  // Execute decode: next values of the state for one opcode.
  logic        wr_vx, push, key_held;
  logic [7:0]  vx_n, vf_n, dt_n, snd_n;
  logic [11:0] pc_n, i_n, pc_skip;
  logic [4:0]  lvl_n;
  logic        disp_n, fault_n;
  op_class_e   op_class;
  logic [8:0]  sum9;

  assign pc_skip  = pc_q + 12'd2;
  assign key_held = (vx_q[7:4] == 4'd0) && keys_q[vx_q[3:0]];
  assign sum9     = {1'b0, vx_q} + {1'b0, vy_q};

  always_comb begin
    wr_vx    = 1'b0;
    push     = 1'b0;
    vx_n     = vx_q;
    vf_n     = vf_q;
    dt_n     = dt_q;
    snd_n    = snd_q;
    pc_n     = pc_q;
    i_n      = i_q;
    lvl_n    = lvl_q;
    disp_n   = 1'b0;
    fault_n  = 1'b0;
    op_class = CLS_SIMPLE;
    case (nib)
      4'h0: begin
        if (op_q == OP_CLS) begin
          disp_n = 1'b1;
        end else if (op_q == OP_RET) begin
          if (lvl_q == 5'd0 || lvl_q > 5'(STACK_DEPTH)) begin
            fault_n = 1'b1;
          end else begin
            lvl_n = lvl_m1;
            pc_n  = sret_q;
          end
        end
      end
      4'h1: pc_n = nnn;
      4'h2: begin
        if (lvl_q >= 5'(STACK_DEPTH)) begin
          fault_n = 1'b1;
        end else begin
          push  = 1'b1;
          lvl_n = lvl_q + 5'd1;
        end
        pc_n = nnn;
      end
      4'h3: if (vx_q == kk) pc_n = pc_skip;
      4'h4: if (vx_q != kk) pc_n = pc_skip;
      4'h5: if (vx_q == vy_q) pc_n = pc_skip;
      4'h6: begin
        wr_vx = 1'b1;
        vx_n  = kk;
      end
      4'h7: begin
        wr_vx = 1'b1;
        vx_n  = vx_q + kk;
      end
      4'h8: begin
        case (n4)
          4'h0: begin wr_vx = 1'b1; vx_n = vy_q; end
          4'h1: begin wr_vx = 1'b1; vx_n = vx_q | vy_q; end
          4'h2: begin wr_vx = 1'b1; vx_n = vx_q & vy_q; end
          4'h3: begin wr_vx = 1'b1; vx_n = vx_q ^ vy_q; end
          4'h4: begin
            wr_vx = 1'b1; op_class = CLS_FLAG;
            vx_n = sum9[7:0];
            vf_n = {7'd0, sum9[8]};
          end
          4'h5: begin
            wr_vx = 1'b1; op_class = CLS_FLAG;
            vx_n = vx_q - vy_q;
            vf_n = {7'd0, vx_q > vy_q};
          end
          4'h6: begin
            wr_vx = 1'b1; op_class = CLS_FLAG;
            vx_n = {1'b0, vx_q[7:1]};
            vf_n = {7'd0, vx_q[0]};
          end
          4'h7: begin
            wr_vx = 1'b1; op_class = CLS_FLAG;
            vx_n = vy_q - vx_q;
            vf_n = {7'd0, vy_q > vx_q};
          end
          4'hE: begin
            wr_vx = 1'b1; op_class = CLS_FLAG;
            vx_n = {vx_q[6:0], 1'b0};
            vf_n = {7'd0, vx_q[7]};
          end
          default: ;
        endcase
      end
      4'h9: if (vx_q != vy_q) pc_n = pc_skip;
      4'hA: i_n = nnn;
      // The register file returns V0 in the execute cycle.
      4'hB: pc_n = {4'd0, gp_val} + nnn;
      4'hC: begin
        wr_vx = 1'b1;
        vx_n  = rnd_q & kk;
      end
      4'hD: disp_n = 1'b1;
      4'hE: begin
        if (kk == KK_SKP && key_held) pc_n = pc_skip;
        else if (kk == KK_SKNP && !key_held) pc_n = pc_skip;
      end
      default: begin
        case (kk)
          KK_LD_DT:  begin wr_vx = 1'b1; vx_n = dt_q; end
          KK_LD_KEY: begin wr_vx = 1'b1; vx_n = {4'd0, wkey_q}; end
          KK_SET_DT: dt_n  = vx_q;
          KK_SET_ST: snd_n = vx_q;
          KK_ADD_I:  i_n   = i_q + {4'd0, vx_q};
          KK_FONT:   i_n   = {2'd0, vx_q, 2'd0} + {4'd0, vx_q};
          KK_BCD:    op_class = CLS_BCD;
          KK_STORE:  op_class = CLS_STORE;
          KK_LOAD:   op_class = CLS_LOAD;
          default: ;
        endcase
      end
    endcase
  end

  // Port steering of the three memories for the current step.
  always_comb begin
    gp_we     = 1'b0;
    gp_addr   = x;
    gp_wdata  = vx_n;
    stk_we    = 1'b0;
    stk_addr  = SAW'(lvl_q);
    mem_a12   = i_q + {8'd0, cnt_q};
    mem_we    = 1'b0;
    mem_wdata = gp_val;
    case (step_i)
      DP_READ_X: stk_addr = SAW'(lvl_m1);
      DP_READ_Y: gp_addr = y;
      DP_READ_0: gp_addr = 4'd0;
      DP_EXEC: begin
        gp_we  = wr_vx;
        stk_we = push;
      end
      DP_WRITE_VF: begin
        gp_we    = 1'b1;
        gp_addr  = 4'hF;
        gp_wdata = vfnew_q;
      end
      DP_BCD: begin
        mem_we    = 1'b1;
        mem_wdata = bcd_digit;
      end
      DP_ST_RD: gp_addr = cnt_q;
      DP_ST_WR: mem_we = 1'b1;
      DP_LD_WR: begin
        gp_we    = 1'b1;
        gp_addr  = cnt_q;
        gp_wdata = mem_val;
      end
      DP_MEM_WR: begin
        mem_a12   = maddr_q;
        mem_we    = 1'b1;
        mem_wdata = wbyte_q;
      end
      DP_MEM_RD: mem_a12 = maddr_q;
      default: ;
    endcase
    mem_in_range = {1'b0, mem_a12} < 13'(MEMORY_BYTES);
    mem_addr     = mem_a12[MAW-1:0];
    mem_we       = mem_we && mem_in_range;
    // The clearing pass after reset loads the font and zeroes the rest.
    if (step_i == DP_CLEAR) begin
      mem_we    = 1'b1;
      mem_addr  = clr_q;
      mem_wdata = font_byte;
    end
  end

  // Item latch, machine state and work registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= 12'(LOAD_ADDRESS);
      i_q      <= 12'd0;
      vf_q     <= 8'd0;
      dt_q     <= 8'd0;
      snd_q    <= 8'd0;
      lvl_q    <= 5'd0;
      gp_vld_q <= 16'd0;
      clr_q    <= '0;
      cmd_q    <= CMD_NONE;
      cnt_q    <= 4'd0;
      rd_q     <= 8'd0;
      disp_q   <= 1'b0;
      fault_q  <= 1'b0;
    end else begin
      if (gp_we) begin
        gp_vld_q[gp_addr] <= 1'b1;
        if (gp_addr == 4'hF) vf_q <= gp_wdata;
      end
      case (step_i)
        DP_CLEAR: clr_q <= clr_q + MAW'(1);
        DP_ACCEPT: begin
          cmd_q   <= cmd_e'(command_i);
          rd_q    <= 8'd0;
          disp_q  <= 1'b0;
          fault_q <= 1'b0;
        end
        DP_READ_X: pc_q <= pc_q + 12'd2;
        DP_EXEC: begin
          pc_q    <= pc_n;
          i_q     <= i_n;
          dt_q    <= dt_n;
          snd_q   <= snd_n;
          lvl_q   <= lvl_n;
          disp_q  <= disp_n;
          fault_q <= fault_n;
          cnt_q   <= 4'd0;
        end
        DP_BCD, DP_ST_WR, DP_LD_WR: cnt_q <= cnt_p1;
        DP_MEM_CAP: rd_q <= mem_val;
        default: ;
      endcase
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    gp_rvld_q <= gp_vld_q[gp_addr];
    if (step_i == DP_ACCEPT) begin
      op_q    <= opcode_i;
      maddr_q <= mem_address_i;
      wbyte_q <= write_byte_i;
      keys_q  <= keypad_mask_i;
      wkey_q  <= waited_key_i;
      rnd_q   <= random_byte_i;
    end
    if (step_i == DP_READ_Y) begin
      vx_q   <= gp_val;
      sret_q <= stk_rdata;
    end
    if (step_i == DP_READ_0) vy_q <= gp_val;
    if (step_i == DP_EXEC) vfnew_q <= vf_n;
    if (step_i == DP_MEM_RD || step_i == DP_LD_RD) mrng_q <= mem_in_range;
  end

  // Status to the controller.
  assign status_o.cmd        = cmd_q;
  assign status_o.op_class   = op_class;
  assign status_o.clear_last = (clr_q == MAW'(MEMORY_BYTES - 1));
  assign status_o.cnt_last   = (step_i == DP_BCD) ? (cnt_q == 4'd2) : (cnt_q == x);

  assign next_pc_o         = pc_q;
  assign index_value_o     = i_q;
  assign flag_value_o      = vf_q;
  assign delay_value_o     = dt_q;
  assign sound_value_o     = snd_q;
  assign read_byte_o       = rd_q;
  assign display_request_o = disp_q;
  assign stack_fault_o     = fault_q;

endmodule

`default_nettype wire

### src/chip8_instruction_execute.sv
// Top level of the CHIP-8 instruction execute unit.
//
// Usage: drive an item on the input ports with start high; it transfers
// at a rising edge where busy is low. Commands: execute one opcode, write
// one memory byte, or read one memory byte. Each item yields one result,
// shown on the result ports for exactly one cycle with done_o high; the
// receiver cannot stall it and must take it in that cycle.
// Work steps after the transfer: a memory write writes its byte; a memory
// read reads the byte and captures it; an opcode reads VX, VY and V0 in
// turn and executes, then writes VF if it sets VF, writes three digits
// for FX33, or moves X+1 bytes for FX55 and FX65.
// The single port of the register file and of the byte memory sets this
// order: each block byte takes a read step and then a write step.
// A new item may transfer in the result cycle.
// After reset a clearing pass loads the font and zeroes the rest of the
// byte memory, all MEMORY_BYTES bytes (4096 by default), with busy high;
// the registers reset to zero and the program counter to LOAD_ADDRESS.
`default_nettype none

module chip8_instruction_execute
  import c8ie_pkg::*;
#(
  parameter int MEMORY_BYTES = MEMORY_BYTES_DEF,
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
  parameter int LOAD_ADDRESS = LOAD_ADDRESS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  output logic             done_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [15:0] opcode_i,
  input  wire logic [11:0] mem_address_i,
  input  wire logic [7:0]  write_byte_i,
  input  wire logic [15:0] keypad_mask_i,
  input  wire logic [3:0]  waited_key_i,
  input  wire logic [7:0]  random_byte_i,
  output logic [11:0]      next_pc_o,
  output logic [11:0]      index_value_o,
  output logic [7:0]       flag_value_o,
  output logic [7:0]       delay_value_o,
  output logic [7:0]       sound_value_o,
  output logic [7:0]       read_byte_o,
  output logic             display_request_o,
  output logic             stack_fault_o
);

  dp_step_e   step;
  dp_status_t status;

  // Sequencer.
  c8ie_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .status_i(status),
    .step_o  (step),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // Machine state and execute logic.
  c8ie_dpath #(
    .MEMORY_BYTES(MEMORY_BYTES),
    .STACK_DEPTH (STACK_DEPTH),
    .LOAD_ADDRESS(LOAD_ADDRESS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .status_o         (status),
    .command_i        (command_i),
    .opcode_i         (opcode_i),
    .mem_address_i    (mem_address_i),
    .write_byte_i     (write_byte_i),
    .keypad_mask_i    (keypad_mask_i),
    .waited_key_i     (waited_key_i),
    .random_byte_i    (random_byte_i),
    .next_pc_o        (next_pc_o),
    .index_value_o    (index_value_o),
    .flag_value_o     (flag_value_o),
    .delay_value_o    (delay_value_o),
    .sound_value_o    (sound_value_o),
    .read_byte_o      (read_byte_o),
    .display_request_o(display_request_o),
    .stack_fault_o    (stack_fault_o)
  );

endmodule

`default_nettype wire

### src/c8ie_checker.sv
// Port-level checks of the CHIP-8 execute unit, bound to the top level.
`default_nettype none

module c8ie_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o,
  input wire logic display_request_o,
  input wire logic stack_fault_o
);

  // A transfer always makes the block busy in the next cycle.
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after a transfer");

  // A result is never shown while the block reports busy.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // Each result lasts exactly one cycle.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  // With no transfer in an idle cycle no result can follow.
  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> !done_o)
    else $error("result without a transfer");

  // Display work and stack faults come from different opcodes.
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(display_request_o && stack_fault_o))
    else $error("display request and stack fault together");

endmodule

bind chip8_instruction_execute c8ie_checker u_c8ie_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .done_o           (done_o),
  .display_request_o(display_request_o),
  .stack_fault_o    (stack_fault_o)
);

`default_nettype wire
